// ----- rtl/transition_count_kl_reward_macros.svh -----
// Assertion macros for the transition count KL reward block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef TRANSITION_COUNT_KL_REWARD_MACROS_SVH
`define TRANSITION_COUNT_KL_REWARD_MACROS_SVH

// same-cycle implication
`define TCKL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tckl assertion failed");

// next-cycle implication
`define TCKL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tckl assertion failed");

`endif

// ----- rtl/tckl_pkg.sv -----
// Shared types and constants of the transition count KL reward block.
// No dependencies.
package tckl_pkg;

	localparam int MAX_SUCCESSORS_DEF   = 16;
	localparam int STATE_INDEX_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF       = 16;

	localparam int PROB_BITS   = 17;
	localparam int FRAC_BITS   = 16;
	localparam int MUL_BITS    = 24;
	localparam int SUM_BITS    = 34;
	localparam int REWARD_BITS = 24;
	localparam int DIV_STEPS   = 17;
	localparam logic [15:0] LN2_Q16 = 16'd45426;

	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_CMP, S_DECIDE, S_PRD, S_PLD, S_DIV, S_NORM,
		S_SQ, S_SQW, S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W, S_NEXT, S_DONE
	} state_t;

endpackage

// ----- rtl/tckl_mem.sv -----
// Successor table storage: one write port, one read port, registered read.
// No dependencies.
module tckl_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 41
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/tckl_mul.sv -----
// Shared unsigned multiplier with registered product.
// Depends on tckl_pkg.
module tckl_mul (
	input  logic                             clk,
	input  logic [tckl_pkg::MUL_BITS-1:0]    a,
	input  logic [tckl_pkg::MUL_BITS-1:0]    b,
	output logic [2*tckl_pkg::MUL_BITS-1:0]  prod
);

	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

// ----- rtl/transition_count_kl_reward.sv -----
// Transition count KL reward: sequencer over a successor table; uses tckl_pkg, tckl_mem, tckl_mul.
// Per word, it scans the table for the observed state, then for every entry recomputes its
// probability with the 17-step divider and, where the new and old probabilities are both
// nonzero, adds a log-difference term through the shared multiplier. A word that finds the
// table full is dropped; the table has a single read port. A new word is taken only when idle.
// Reset clears the sequencer and successor count; done strobes one cycle, receiver can't stall.
`include "transition_count_kl_reward_macros.svh"

module transition_count_kl_reward #(
	parameter int MAX_SUCCESSORS   = tckl_pkg::MAX_SUCCESSORS_DEF,
	parameter int STATE_INDEX_BITS = tckl_pkg::STATE_INDEX_BITS_DEF,
	parameter int COUNT_BITS       = tckl_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [STATE_INDEX_BITS-1:0] observed_state,
	output logic                        done,
	output logic signed [23:0]          reward,
	output logic                        was_new,
	output logic                        table_full,
	output logic [4:0]                  successor_count
);

	localparam int IW = $clog2(MAX_SUCCESSORS);
	localparam int UW = $clog2(MAX_SUCCESSORS + 1);
	localparam int TW = COUNT_BITS + IW;
	localparam int PB = tckl_pkg::PROB_BITS;
	localparam int MW = tckl_pkg::MUL_BITS;
	localparam int DW = STATE_INDEX_BITS + COUNT_BITS + PB;
	localparam logic [COUNT_BITS-1:0] CNT_LIM = {COUNT_BITS{1'b1}};
	localparam logic [UW-1:0] USED_MAX = UW'(MAX_SUCCESSORS);

	tckl_pkg::state_t state_q, state_d;

	logic [UW-1:0]               used_q;
	logic [UW-1:0]               i_q;
	logic [STATE_INDEX_BITS-1:0] id_q, eid_q;
	logic [TW-1:0]               total_q;
	logic                        found_q, wasnew_q, full_q;
	logic [IW-1:0]               slot_q;
	logic [COUNT_BITS-1:0]       cnt_q, cnt_e_q;
	logic [PB-1:0]               q_q, p_q, x_q, y_q;
	logic [TW:0]                 rem_q;
	logic [PB-1:0]               quo_q;
	logic [4:0]                  dc_q, fc_q, s_q, sp_q;
	logic [15:0]                 frac_q, fp_q;
	logic                        ph_q, dneg_q;
	logic [20:0]                 ad_q;
	logic [37:0]                 m1_q;
	logic [34:0]                 acc_q;
	logic signed [tckl_pkg::SUM_BITS-1:0] sum_q;

	logic          mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [DW-1:0] mem_wdata, mem_rdata;
	logic [MW-1:0] mul_a, mul_b;
	logic [2*MW-1:0] prod;

	logic [PB-1:0]               rd_p;
	logic [COUNT_BITS-1:0]       rd_count;
	logic [STATE_INDEX_BITS-1:0] rd_id;

	assign rd_p     = mem_rdata[PB-1:0];
	assign rd_count = mem_rdata[PB +: COUNT_BITS];
	assign rd_id    = mem_rdata[PB+COUNT_BITS +: STATE_INDEX_BITS];

	tckl_mem #(.DEPTH(MAX_SUCCESSORS), .AW(IW), .DW(DW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	tckl_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

	// divider step
	logic          div_ge;
	logic [PB-1:0] p_new;
	logic          div_last;
	assign div_ge   = rem_q >= {1'b0, total_q};
	assign p_new    = {quo_q[PB-2:0], div_ge};
	assign div_last = dc_q == 5'd1;

	// squaring step
	logic [17:0] y2;
	logic        sq_bit;
	logic [15:0] frac_new;
	assign y2       = prod[33:16];
	assign sq_bit   = y2[17];
	assign frac_new = {frac_q[14:0], sq_bit};

	// log difference
	logic [5:0]         sd;
	logic signed [22:0] d_c;
	logic [22:0]        d_abs;
	assign sd    = {1'b0, s_q} - {1'b0, sp_q};
	assign d_c   = {sd[5], sd, 16'b0} + 23'(fp_q) - 23'(frac_new);
	assign d_abs = d_c[22] ? 23'(-d_c) : d_c;

	// term magnitude
	logic [53:0] mag_full;
	logic [21:0] mag;
	assign mag_full = 54'(acc_q) + (54'(prod[34:0]) << 19);
	assign mag      = mag_full[53:32];

	logic [COUNT_BITS-1:0] cnt_base;
	logic                  cnt_inc;
	assign cnt_base = found_q ? cnt_q : '0;
	assign cnt_inc  = cnt_base < CNT_LIM;

	logic last_entry;
	assign last_entry = (i_q + UW'(1)) == used_q;

	logic full_now;
	assign full_now = !found_q && used_q == USED_MAX;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = i_q[IW-1:0];
		mem_wdata = {eid_q, cnt_e_q, p_new};
		mem_raddr = i_q[IW-1:0];
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			tckl_pkg::S_IDLE: begin
				if (start) state_d = (used_q == '0) ? tckl_pkg::S_DECIDE : tckl_pkg::S_RD;
			end
			tckl_pkg::S_RD: state_d = tckl_pkg::S_CMP;
			tckl_pkg::S_CMP: state_d = last_entry ? tckl_pkg::S_DECIDE : tckl_pkg::S_RD;
			tckl_pkg::S_DECIDE: begin
				if (full_now) begin
					state_d = tckl_pkg::S_DONE;
				end else begin
					state_d = tckl_pkg::S_PRD;
					if (!found_q) begin
						mem_we    = 1'b1;
						mem_waddr = used_q[IW-1:0];
						mem_wdata = {id_q, {COUNT_BITS{1'b0}}, {PB{1'b0}}};
					end
				end
			end
			tckl_pkg::S_PRD: state_d = tckl_pkg::S_PLD;
			tckl_pkg::S_PLD: state_d = tckl_pkg::S_DIV;
			tckl_pkg::S_DIV: begin
				if (div_last) begin
					mem_we  = 1'b1;
					state_d = (p_new != '0 && q_q != '0) ? tckl_pkg::S_NORM
						: tckl_pkg::S_NEXT;
				end
			end
			tckl_pkg::S_NORM: if (x_q[PB-1]) state_d = tckl_pkg::S_SQ;
			tckl_pkg::S_SQ: begin
				mul_a   = MW'(y_q);
				mul_b   = MW'(y_q);
				state_d = tckl_pkg::S_SQW;
			end
			tckl_pkg::S_SQW: begin
				if (fc_q == 5'd1) state_d = ph_q ? tckl_pkg::S_M1 : tckl_pkg::S_NORM;
				else state_d = tckl_pkg::S_SQ;
			end
			tckl_pkg::S_M1: begin
				mul_a   = MW'(p_q);
				mul_b   = MW'(ad_q);
				state_d = tckl_pkg::S_M1W;
			end
			tckl_pkg::S_M1W: state_d = tckl_pkg::S_M2;
			tckl_pkg::S_M2: begin
				mul_a   = MW'(m1_q[18:0]);
				mul_b   = MW'(tckl_pkg::LN2_Q16);
				state_d = tckl_pkg::S_M2W;
			end
			tckl_pkg::S_M2W: state_d = tckl_pkg::S_M3;
			tckl_pkg::S_M3: begin
				mul_a   = MW'(m1_q[37:19]);
				mul_b   = MW'(tckl_pkg::LN2_Q16);
				state_d = tckl_pkg::S_M3W;
			end
			tckl_pkg::S_M3W: state_d = tckl_pkg::S_NEXT;
			tckl_pkg::S_NEXT: state_d = last_entry ? tckl_pkg::S_DONE : tckl_pkg::S_PRD;
			tckl_pkg::S_DONE: state_d = tckl_pkg::S_IDLE;
			default: state_d = tckl_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tckl_pkg::S_IDLE;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tckl_pkg::S_DECIDE && !found_q && !full_now) begin
				used_q <= used_q + UW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tckl_pkg::S_IDLE: begin
				if (start) begin
					id_q     <= observed_state;
					i_q      <= '0;
					total_q  <= '0;
					found_q  <= 1'b0;
					wasnew_q <= 1'b0;
					full_q   <= 1'b0;
					sum_q    <= '0;
				end
			end
			tckl_pkg::S_CMP: begin
				total_q <= total_q + TW'(rd_count);
				if (rd_id == id_q) begin
					found_q <= 1'b1;
					slot_q  <= i_q[IW-1:0];
					cnt_q   <= rd_count;
				end
				i_q <= i_q + UW'(1);
			end
			tckl_pkg::S_DECIDE: begin
				if (full_now) begin
					full_q <= 1'b1;
				end else begin
					if (!found_q) begin
						slot_q   <= used_q[IW-1:0];
						wasnew_q <= 1'b1;
					end
					cnt_q   <= cnt_inc ? cnt_base + COUNT_BITS'(1) : cnt_base;
					total_q <= total_q + TW'(cnt_inc);
					i_q     <= '0;
				end
			end
			tckl_pkg::S_PLD: begin
				cnt_e_q <= (i_q[IW-1:0] == slot_q) ? cnt_q : rd_count;
				rem_q   <= (i_q[IW-1:0] == slot_q) ? (TW+1)'(cnt_q) : (TW+1)'(rd_count);
				q_q     <= rd_p;
				eid_q   <= rd_id;
				quo_q   <= '0;
				dc_q    <= 5'(tckl_pkg::DIV_STEPS);
			end
			tckl_pkg::S_DIV: begin
				rem_q <= (div_ge ? rem_q - {1'b0, total_q} : rem_q) << 1;
				quo_q <= p_new;
				dc_q  <= dc_q - 5'd1;
				if (div_last) begin
					p_q  <= p_new;
					x_q  <= p_new;
					s_q  <= '0;
					ph_q <= 1'b0;
				end
			end
			tckl_pkg::S_NORM: begin
				if (!x_q[PB-1]) begin
					x_q <= x_q << 1;
					s_q <= s_q + 5'd1;
				end else begin
					y_q    <= x_q;
					fc_q   <= 5'd16;
					frac_q <= '0;
				end
			end
			tckl_pkg::S_SQW: begin
				y_q    <= sq_bit ? y2[17:1] : y2[16:0];
				frac_q <= frac_new;
				fc_q   <= fc_q - 5'd1;
				if (fc_q == 5'd1) begin
					if (!ph_q) begin
						sp_q <= s_q;
						fp_q <= frac_new;
						x_q  <= q_q;
						s_q  <= '0;
						ph_q <= 1'b1;
					end else begin
						dneg_q <= d_c[22];
						ad_q   <= d_abs[20:0];
					end
				end
			end
			tckl_pkg::S_M1W: m1_q <= prod[37:0];
			tckl_pkg::S_M2W: acc_q <= prod[34:0];
			tckl_pkg::S_M3W: begin
				if (dneg_q) sum_q <= sum_q - tckl_pkg::SUM_BITS'(mag);
				else sum_q <= sum_q + tckl_pkg::SUM_BITS'(mag);
			end
			tckl_pkg::S_NEXT: i_q <= i_q + UW'(1);
			default: ;
		endcase
	end

	localparam logic signed [tckl_pkg::SUM_BITS-1:0] RMAX = tckl_pkg::SUM_BITS'(8388607);
	localparam logic signed [tckl_pkg::SUM_BITS-1:0] RMIN = -tckl_pkg::SUM_BITS'(8388608);

	logic [31:0] used_ext;
	assign used_ext = 32'(used_q);

	assign busy            = state_q != tckl_pkg::S_IDLE;
	assign done            = state_q == tckl_pkg::S_DONE;
	assign was_new         = wasnew_q;
	assign table_full      = full_q;
	assign successor_count = used_ext[4:0];

	always_comb begin
		if (sum_q > RMAX) reward = 24'sh7FFFFF;
		else if (sum_q < RMIN) reward = -24'sh800000;
		else reward = sum_q[23:0];
	end

	`TCKL_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`TCKL_ASSERT_NEXT(a_done_idle, done, !busy)
	`TCKL_ASSERT_NOW(a_new_full_excl, done, !(was_new && table_full))
	`TCKL_ASSERT_NOW(a_used_bound, busy, used_q <= USED_MAX)
	`TCKL_ASSERT_NOW(a_full_zero, done && table_full, reward == 24'sd0)

endmodule

// ----- tb/transition_count_kl_reward_checker.sv -----
// Checker for the transition count KL reward block: watches the start and done words,
// predicts each result from its own copy of the successor table and compares. Uses tckl_pkg.
`timescale 1ns / 1ps

module transition_count_kl_reward_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [7:0]         observed_state,
	input  logic               done,
	input  logic signed [23:0] reward,
	input  logic               was_new,
	input  logic               table_full,
	input  logic [4:0]         successor_count,
	output int                 fail_count,
	output int                 pending
);

	localparam int DEPTH = tckl_pkg::MAX_SUCCESSORS_DEF;
	localparam longint COUNT_MAX = (64'd1 << tckl_pkg::COUNT_BITS_DEF) - 1;

	typedef struct packed {
		logic signed [23:0] reward;
		logic               was_new;
		logic               table_full;
		logic [4:0]         successor_count;
	} kl_word_t;

	logic [7:0]                     succ_id [DEPTH];
	logic [15:0]                    visits [DEPTH];
	logic [tckl_pkg::PROB_BITS-1:0] prob [DEPTH];
	logic [tckl_pkg::PROB_BITS-1:0] prob_prev [DEPTH];
	int                             used;
	kl_word_t                       expected_words [$];

	// Save p as q, then p = count * 2^16 / total.
	function automatic void refresh_probs();
		longint total;
		total = 0;
		for (int i = 0; i < used; i++) total += visits[i];
		for (int i = 0; i < used; i++) begin
			prob_prev[i] = prob[i];
			if (total == 0) prob[i] = '0;
			else prob[i] = tckl_pkg::PROB_BITS'((longint'(visits[i]) << 16) / total);
		end
	endfunction

	function automatic longint log2_q16(longint x);
		int     k;
		longint y;
		longint frac;
		k = 0;
		frac = 0;
		while (k < 16 && (x >> (k + 1)) != 0) k++;
		y = x << (16 - k);
		for (int i = 15; i >= 0; i--) begin
			y = (y * y) >> 16;
			if (y >= 2 * 65536) begin
				y = y >> 1;
				frac = frac | (longint'(1) << i);
			end
		end
		return (longint'(k) - 16) * 65536 + frac;
	endfunction

	function automatic longint kl_divergence();
		longint sum, d, mag;
		sum = 0;
		for (int i = 0; i < used; i++) begin
			if (prob[i] != 0 && prob_prev[i] != 0) begin
				d = log2_q16(longint'(prob[i])) - log2_q16(longint'(prob_prev[i]));
				mag = d < 0 ? -d : d;
				mag = (longint'(prob[i]) * mag * longint'(tckl_pkg::LN2_Q16)) >>> 32;
				sum = d < 0 ? sum - mag : sum + mag;
			end
		end
		return sum;
	endfunction

	function automatic kl_word_t predict_word(logic [7:0] id);
		kl_word_t w;
		int       slot;
		bit       found;
		longint   r;
		w = '0;
		slot = 0;
		found = 0;
		r = 0;
		for (int i = 0; i < used; i++)
			if (!found && succ_id[i] == id) begin
				slot = i;
				found = 1;
			end
		if (!found && used >= DEPTH) begin
			w.table_full = 1'b1;
		end else begin
			if (!found) begin
				slot = used;
				succ_id[slot] = id;
				visits[slot] = '0;
				prob[slot] = '0;
				prob_prev[slot] = '0;
				used++;
				w.was_new = 1'b1;
				refresh_probs();
			end
			if (visits[slot] < COUNT_MAX) visits[slot] = visits[slot] + 16'd1;
			refresh_probs();
			r = kl_divergence();
			if (r > 8388607) r = 8388607;
			if (r < -8388608) r = -8388608;
		end
		w.reward = r[23:0];
		w.successor_count = 5'(used);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kl_word_t exp_w;
		if (!arst_n) begin
			used = 0;
			fail_count = 0;
			expected_words.delete();
		end else begin
			if (done) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word: reward %0d", reward);
				end else begin
					exp_w = expected_words.pop_front();
					if (exp_w.reward !== reward || exp_w.was_new !== was_new ||
					    exp_w.table_full !== table_full ||
					    exp_w.successor_count !== successor_count) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: expected reward %0d new %b full %b count %0d,",
								" got reward %0d new %b full %b count %0d"},
								exp_w.reward, exp_w.was_new, exp_w.table_full,
								exp_w.successor_count, reward, was_new, table_full,
								successor_count);
					end
				end
			end
			if (start && !busy)
				expected_words = {expected_words, predict_word(observed_state)};
		end
		pending = expected_words.size();
	end

endmodule

// ----- tb/transition_count_kl_reward_test.sv -----
// Top of the transition count KL reward testbench: drives observations, gives the verdict.
// Depends on tckl_pkg, the block and transition_count_kl_reward_checker.
`timescale 1ns / 1ps

module transition_count_kl_reward_test;
	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [7:0]         observed_state;
	logic               done;
	logic signed [23:0] reward;
	logic               was_new;
	logic               table_full;
	logic [4:0]         successor_count;
	int                 fail_count;
	int                 pending;
	int                 idle_pct;
	logic [7:0]         known_ids [$];

	transition_count_kl_reward u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.observed_state(observed_state), .done(done), .reward(reward),
		.was_new(was_new), .table_full(table_full), .successor_count(successor_count)
	);

	transition_count_kl_reward_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.observed_state(observed_state), .done(done), .reward(reward),
		.was_new(was_new), .table_full(table_full), .successor_count(successor_count),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("[transition_count_kl_reward] ERROR");
		$finish;
	end

	// Hold the word until accepted, then maybe drop start for a gap.
	task automatic send_word(logic [7:0] id);
		int gap;
		observed_state <= id;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (!(id inside {known_ids}) && known_ids.size() < 16) known_ids = {known_ids, id};
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic [7:0] directed [];
		int pick;
		directed = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd2, 8'd4,
			8'd8, 8'd16, 8'd32, 8'd64, 8'd128, 8'd170, 8'd85, 8'd254, 8'd127, 8'd3,
			8'd200, 8'd99, 8'd0, 8'd77, 8'd255};
		arst_n = 1'b0;
		start = 1'b0;
		observed_state = '0;
		idle_pct = 34;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_word(directed[i]);
		for (int n = 0; n < 1000; n++) begin
			if (n == 333) idle_pct = 70;
			if (n == 666) idle_pct = 0;
			if ($urandom_range(99) < 85) begin
				// skew toward low slots so the distribution keeps moving
				pick = $urandom_range(0, $urandom_range(0, known_ids.size() - 1));
				send_word(known_ids[pick]);
			end else begin
				send_word(8'($urandom_range(255)));
			end
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("[transition_count_kl_reward] OK");
		end else begin
			$display("[transition_count_kl_reward] ERROR");
		end
		$finish;
	end

endmodule
